/* rtl/tlef_pkg.sv */
// Shared types, constants and the microcode program of the tank level echo filter.
// Used by tank_level_echo_filter_hysteresis; depends on nothing else.

package tlef_pkg;

    // Field widths
    localparam int ECHO_W  = 15;
    localparam int DIST_W  = 20;
    localparam int THR_W   = 18;
    localparam int WGT_W   = 9;
    localparam int M_W     = 26;  // distance in Q16 cm
    localparam int SQ_W    = 35;  // distance squared in Q16 cm^2
    localparam int ACC_W   = 61;  // calibration sum in Q48
    localparam int MUL_A_W = 27;
    localparam int MUL_B_W = 32;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int STEP_W  = 4;
    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 24;

    // Register indexes
    localparam logic [1:0] REG_WARNING_START     = 2'd0;
    localparam logic [1:0] REG_STOP_THRESHOLD    = 2'd1;
    localparam logic [1:0] REG_RESTART_THRESHOLD = 2'd2;
    localparam logic [1:0] REG_SMOOTHING_WEIGHT  = 2'd3;

    localparam logic [THR_W-1:0] WARNING_START_RST     = 18'd3840;
    localparam logic [THR_W-1:0] STOP_THRESHOLD_RST    = 18'd6400;
    localparam logic [THR_W-1:0] RESTART_THRESHOLD_RST = 18'd5632;
    localparam logic [WGT_W-1:0] SMOOTHING_WEIGHT_RST  = 9'd64;

    localparam logic [ECHO_W-1:0] ECHO_TIMEOUT = 15'd30000;

    // 0.01715 cm/us in Q24
    localparam logic [18:0] K_DIST = 19'd287729;
    // 1.256231 in Q32 minus 2^32; the 2^32 part is added as a shift
    localparam logic [30:0] CAL_B_LO = 31'd1100503765;
    // 0.00379202 in Q32
    localparam logic [23:0] CAL_A = 24'd16286602;
    // 3.132942 in Q48
    localparam logic [ACC_W-1:0] CAL_C_Q48 = 61'd13455883430 << 16;
    localparam logic [ACC_W-1:0] ROUND_HALF = 61'd1 << 39;

    localparam logic [DIST_W-1:0] DIST_MAX = 20'h7FFFF;
    localparam logic [DIST_W-1:0] DIST_MIN = 20'h80000;

    // Multiplier operand selects
    localparam logic [2:0] MUL_NONE   = 3'd0;
    localparam logic [2:0] MUL_ECHO_K = 3'd1;
    localparam logic [2:0] MUL_M_M    = 3'd2;
    localparam logic [2:0] MUL_M_B    = 3'd3;
    localparam logic [2:0] MUL_SQLO_A = 3'd4;
    localparam logic [2:0] MUL_SQHI_A = 3'd5;
    localparam logic [2:0] MUL_EMA    = 3'd6;

    // Accumulator operations
    localparam logic [2:0] ACC_NONE   = 3'd0;
    localparam logic [2:0] ACC_POS    = 3'd1;
    localparam logic [2:0] ACC_SUB    = 3'd2;
    localparam logic [2:0] ACC_SUB_HI = 3'd3;
    localparam logic [2:0] ACC_ABS    = 3'd4;

    // Register loads
    localparam logic [2:0] LD_NONE    = 3'd0;
    localparam logic [2:0] LD_M       = 3'd1;
    localparam logic [2:0] LD_SQ      = 3'd2;
    localparam logic [2:0] LD_CAL     = 3'd3;
    localparam logic [2:0] LD_EMA     = 3'd4;
    localparam logic [2:0] LD_SEED    = 3'd5;
    localparam logic [2:0] LD_OUT     = 3'd6;
    localparam logic [2:0] LD_OUT_INV = 3'd7;

    // Jump conditions
    localparam logic [1:0] J_NONE     = 2'd0;
    localparam logic [1:0] J_NO_ECHO  = 2'd1;
    localparam logic [1:0] J_UNSEEDED = 2'd2;
    localparam logic [1:0] J_ALWAYS   = 2'd3;

    // Program steps
    localparam logic [STEP_W-1:0] ST_MUL_K   = 4'd0;
    localparam logic [STEP_W-1:0] ST_LD_M    = 4'd1;
    localparam logic [STEP_W-1:0] ST_MUL_MM  = 4'd2;
    localparam logic [STEP_W-1:0] ST_LD_SQ   = 4'd3;
    localparam logic [STEP_W-1:0] ST_POS     = 4'd4;
    localparam logic [STEP_W-1:0] ST_SUB_LO  = 4'd5;
    localparam logic [STEP_W-1:0] ST_SUB_HI  = 4'd6;
    localparam logic [STEP_W-1:0] ST_ABS     = 4'd7;
    localparam logic [STEP_W-1:0] ST_ROUND   = 4'd8;
    localparam logic [STEP_W-1:0] ST_EMA_MUL = 4'd9;
    localparam logic [STEP_W-1:0] ST_EMA_SUM = 4'd10;
    localparam logic [STEP_W-1:0] ST_SEED    = 4'd11;
    localparam logic [STEP_W-1:0] ST_OUT     = 4'd12;
    localparam logic [STEP_W-1:0] ST_OUT_INV = 4'd13;

    typedef struct packed {
        logic [2:0]        mul_sel;
        logic [2:0]        acc_op;
        logic [2:0]        ld;
        logic [1:0]        jcond;
        logic [STEP_W-1:0] jto;
        logic              last;
    } ctrl_t;

    function automatic ctrl_t ucode_rom(input logic [STEP_W-1:0] step);
        ctrl_t cw;
        cw = '{mul_sel: MUL_NONE, acc_op: ACC_NONE, ld: LD_NONE,
               jcond: J_NONE, jto: ST_MUL_K, last: 1'b0};
        unique case (step)
            ST_MUL_K: begin
                cw.mul_sel = MUL_ECHO_K;
                cw.jcond   = J_NO_ECHO;
                cw.jto     = ST_OUT_INV;
            end
            ST_LD_M:    cw.ld = LD_M;
            ST_MUL_MM:  cw.mul_sel = MUL_M_M;
            ST_LD_SQ: begin
                cw.ld      = LD_SQ;
                cw.mul_sel = MUL_M_B;
            end
            ST_POS: begin
                cw.acc_op  = ACC_POS;
                cw.mul_sel = MUL_SQLO_A;
            end
            ST_SUB_LO: begin
                cw.acc_op  = ACC_SUB;
                cw.mul_sel = MUL_SQHI_A;
            end
            ST_SUB_HI:  cw.acc_op = ACC_SUB_HI;
            ST_ABS:     cw.acc_op = ACC_ABS;
            ST_ROUND:   cw.ld = LD_CAL;
            ST_EMA_MUL: begin
                cw.mul_sel = MUL_EMA;
                cw.jcond   = J_UNSEEDED;
                cw.jto     = ST_SEED;
            end
            ST_EMA_SUM: begin
                cw.ld    = LD_EMA;
                cw.jcond = J_ALWAYS;
                cw.jto   = ST_OUT;
            end
            ST_SEED:    cw.ld = LD_SEED;
            ST_OUT: begin
                cw.ld   = LD_OUT;
                cw.last = 1'b1;
            end
            ST_OUT_INV: begin
                cw.ld   = LD_OUT_INV;
                cw.last = 1'b1;
            end
            default:    cw.last = 1'b1;
        endcase
        return cw;
    endfunction

endpackage

/* rtl/tank_level_echo_filter_hysteresis.sv */
// Tank level echo filter: microcoded sequencer with one shared multiplier.
// Depends on tlef_pkg for constants, the control word type and the program.

// Each request carries one echo time in microseconds (zero or above 30000 means
// no echo). An echo runs the whole program from acceptance to a result in the
// output register; a missing echo jumps straight to the invalid-output step.
// A new request is taken only after the previous one has left the final step.
// The program walks one 27x32 multiplier and one 61-bit
// accumulator through the distance, calibration and smoothing steps. A finished
// result waits in the output register while the next request is taken; the
// final step stalls only if a result is still held there and not being taken. Configuration writes
// are always accepted and should be made while no request is in flight.

module tank_level_echo_filter_hysteresis (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // [14:0] echo_time, [15] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,    // [0] distance_valid, [20:1] filtered_distance,
                                    // [21] tank_warning, [22] pump_stop, [23] zero
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [17:0] cfg_data
);

    // Configuration registers
    logic [tlef_pkg::THR_W-1:0] warning_start_reg;
    logic [tlef_pkg::THR_W-1:0] stop_threshold_reg;
    logic [tlef_pkg::THR_W-1:0] restart_threshold_reg;
    logic [tlef_pkg::WGT_W-1:0] smoothing_weight_reg;

    // Sequencer
    logic                        busy_reg;
    logic [tlef_pkg::STEP_W-1:0] step_reg;
    tlef_pkg::ctrl_t             cw;
    logic                        jump_take;
    logic                        out_free;

    // Datapath
    logic [tlef_pkg::ECHO_W-1:0]      echo_reg;
    logic [tlef_pkg::M_W-1:0]         m_reg;
    logic [tlef_pkg::SQ_W-1:0]        sq_reg;
    logic [tlef_pkg::PROD_W-1:0]      prod_reg;
    logic [tlef_pkg::ACC_W-1:0]       acc_reg;
    logic [tlef_pkg::ACC_W-1:0]       acc_next;
    logic                             neg_reg;
    logic [tlef_pkg::DIST_W-1:0]      cal_reg;
    logic [tlef_pkg::DIST_W-1:0]      smoothed_reg;
    logic                             seeded_reg;
    logic                             low_water_reg;
    logic                             low_water_next;
    logic                             m_tvalid_reg;
    logic [tlef_pkg::M_DATA_W-1:0]    m_tdata_reg;

    logic signed [tlef_pkg::MUL_A_W-1:0] mul_a;
    logic signed [tlef_pkg::MUL_B_W-1:0] mul_b;
    logic signed [tlef_pkg::PROD_W-1:0]  mul_p;

    logic                          no_echo;
    logic [tlef_pkg::WGT_W-1:0]    w_eff;
    logic [tlef_pkg::DIST_W:0]     ema_diff;
    logic [tlef_pkg::ACC_W-1:0]    prod_ext;
    logic [tlef_pkg::ACC_W-1:0]    rnd_sum;
    logic [tlef_pkg::DIST_W:0]     rnd_mag;
    logic [tlef_pkg::DIST_W:0]     rnd_neg;
    logic [tlef_pkg::DIST_W-1:0]   cal_next;
    logic [30:0]                   ema_sum;
    logic [22:0]                   ema_f;
    logic [tlef_pkg::DIST_W-1:0]   ema_next;
    logic [18:0]                   f_mag;
    logic                          f_sgn;
    logic                          f_gt_stop;
    logic                          f_lt_restart;
    logic                          f_ge_warn;
    logic                          f_le_stop;
    logic                          warn;
    logic [8:0]                    m_sum;

    assign s_tready  = !busy_reg;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign out_free  = !m_tvalid_reg || m_tready;

    assign cw = tlef_pkg::ucode_rom(step_reg);

    assign no_echo = (echo_reg == '0) || (echo_reg > tlef_pkg::ECHO_TIMEOUT);

    always_comb begin
        unique case (cw.jcond)
            tlef_pkg::J_NONE:     jump_take = 1'b0;
            tlef_pkg::J_NO_ECHO:  jump_take = no_echo;
            tlef_pkg::J_UNSEEDED: jump_take = !seeded_reg;
            tlef_pkg::J_ALWAYS:   jump_take = 1'b1;
            default:              jump_take = 1'b0;
        endcase
    end

    // Weights above 256 act as 256
    assign w_eff    = smoothing_weight_reg[8] ? 9'd256 : smoothing_weight_reg;
    assign ema_diff = {cal_reg[19], cal_reg} - {smoothed_reg[19], smoothed_reg};

    // Shared multiplier operand select
    always_comb begin
        case (cw.mul_sel)
            tlef_pkg::MUL_ECHO_K: begin
                mul_a = $signed({12'd0, echo_reg});
                mul_b = $signed({13'd0, tlef_pkg::K_DIST});
            end
            tlef_pkg::MUL_M_M: begin
                mul_a = $signed({1'b0, m_reg});
                mul_b = $signed({6'd0, m_reg});
            end
            tlef_pkg::MUL_M_B: begin
                mul_a = $signed({1'b0, m_reg});
                mul_b = $signed({1'b0, tlef_pkg::CAL_B_LO});
            end
            tlef_pkg::MUL_SQLO_A: begin
                mul_a = $signed({9'd0, sq_reg[17:0]});
                mul_b = $signed({8'd0, tlef_pkg::CAL_A});
            end
            tlef_pkg::MUL_SQHI_A: begin
                mul_a = $signed({10'd0, sq_reg[34:18]});
                mul_b = $signed({8'd0, tlef_pkg::CAL_A});
            end
            tlef_pkg::MUL_EMA: begin
                mul_a = $signed({{6{ema_diff[20]}}, ema_diff});
                mul_b = $signed({23'd0, w_eff});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p    = mul_a * mul_b;
    assign prod_ext = {{2{prod_reg[58]}}, prod_reg};

    // Calibration accumulator in Q48
    always_comb begin
        case (cw.acc_op)
            tlef_pkg::ACC_POS:
                acc_next = {3'd0, m_reg, 32'd0} + prod_ext - tlef_pkg::CAL_C_Q48;
            tlef_pkg::ACC_SUB:    acc_next = acc_reg - prod_ext;
            tlef_pkg::ACC_SUB_HI: acc_next = acc_reg - {prod_reg[42:0], 18'd0};
            tlef_pkg::ACC_ABS:    acc_next = acc_reg[60] ? (~acc_reg + 61'd1) : acc_reg;
            default:              acc_next = acc_reg;
        endcase
    end

    // Round magnitude half away from zero, restore sign, saturate
    assign rnd_sum = acc_reg + tlef_pkg::ROUND_HALF;
    assign rnd_mag = rnd_sum[60:40];
    assign rnd_neg = ~rnd_mag + 21'd1;

    always_comb begin
        if (!neg_reg) begin
            cal_next = (rnd_mag > 21'd524287) ? tlef_pkg::DIST_MAX : rnd_mag[19:0];
        end else begin
            cal_next = (rnd_mag > 21'd524288) ? tlef_pkg::DIST_MIN : rnd_neg[19:0];
        end
    end

    // prev*256 + w*(cal - prev) + 128, floored by the arithmetic shift
    assign ema_sum = {{3{smoothed_reg[19]}}, smoothed_reg, 8'd0} + prod_reg[30:0] + 31'd128;
    assign ema_f   = ema_sum[30:8];

    always_comb begin
        if (ema_f[22:19] == {4{ema_f[22]}}) begin
            ema_next = ema_f[19:0];
        end else begin
            ema_next = ema_f[22] ? tlef_pkg::DIST_MIN : tlef_pkg::DIST_MAX;
        end
    end

    // Flags against the committed filter value
    assign f_sgn        = smoothed_reg[19];
    assign f_mag        = smoothed_reg[18:0];
    assign f_gt_stop    = !f_sgn && (f_mag > {1'b0, stop_threshold_reg});
    assign f_lt_restart = f_sgn || (f_mag < {1'b0, restart_threshold_reg});
    assign f_ge_warn    = !f_sgn && (f_mag >= {1'b0, warning_start_reg});
    assign f_le_stop    = f_sgn || (f_mag <= {1'b0, stop_threshold_reg});
    assign warn         = f_ge_warn && f_le_stop;

    always_comb begin
        low_water_next = low_water_reg;
        if (!low_water_reg && f_gt_stop) begin
            low_water_next = 1'b1;
        end else if (low_water_reg && f_lt_restart) begin
            low_water_next = 1'b0;
        end
    end

    // round to nearest: carry bit 7 into the kept bits
    assign m_sum = {1'b0, prod_reg[15:8]} + {8'd0, prod_reg[7]};

    // Configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            warning_start_reg     <= tlef_pkg::WARNING_START_RST;
            stop_threshold_reg    <= tlef_pkg::STOP_THRESHOLD_RST;
            restart_threshold_reg <= tlef_pkg::RESTART_THRESHOLD_RST;
            smoothing_weight_reg  <= tlef_pkg::SMOOTHING_WEIGHT_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                tlef_pkg::REG_WARNING_START:     warning_start_reg     <= cfg_data;
                tlef_pkg::REG_STOP_THRESHOLD:    stop_threshold_reg    <= cfg_data;
                tlef_pkg::REG_RESTART_THRESHOLD: restart_threshold_reg <= cfg_data;
                tlef_pkg::REG_SMOOTHING_WEIGHT:  smoothing_weight_reg  <= cfg_data[8:0];
                default: ;
            endcase
        end
    end

    // Sequencer and state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            step_reg      <= tlef_pkg::ST_MUL_K;
            seeded_reg    <= 1'b0;
            low_water_reg <= 1'b0;
            smoothed_reg  <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            if (busy_reg && cw.last && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (!busy_reg) begin
                if (s_tvalid) begin
                    busy_reg <= 1'b1;
                    step_reg <= tlef_pkg::ST_MUL_K;
                end
            end else if (cw.last) begin
                // hold the final step until the output register is free
                if (out_free) begin
                    busy_reg     <= 1'b0;
                    step_reg     <= tlef_pkg::ST_MUL_K;
                    if (cw.ld == tlef_pkg::LD_OUT) begin
                        low_water_reg <= low_water_next;
                    end else begin
                        low_water_reg <= 1'b0;
                    end
                end
            end else begin
                step_reg <= jump_take ? cw.jto : step_reg + 4'd1;
            end

            if (busy_reg && cw.ld == tlef_pkg::LD_EMA) begin
                smoothed_reg <= ema_next;
            end
            if (busy_reg && cw.ld == tlef_pkg::LD_SEED) begin
                smoothed_reg <= cal_reg;
                seeded_reg   <= 1'b1;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        if (!busy_reg && s_tvalid) begin
            echo_reg <= s_tdata[14:0];
        end
        if (busy_reg) begin
            prod_reg <= mul_p;
            acc_reg  <= acc_next;
            if (cw.acc_op == tlef_pkg::ACC_ABS) begin
                neg_reg <= acc_reg[60];
            end
            case (cw.ld)
                tlef_pkg::LD_M:   m_reg   <= {prod_reg[33:16], 8'd0} + {17'd0, m_sum};
                tlef_pkg::LD_SQ:  sq_reg  <= prod_reg[50:16];
                tlef_pkg::LD_CAL: cal_reg <= cal_next;
                tlef_pkg::LD_OUT: begin
                    if (out_free) begin
                        m_tdata_reg <= {1'b0, low_water_next, warn, smoothed_reg, 1'b1};
                    end
                end
                tlef_pkg::LD_OUT_INV: begin
                    if (out_free) begin
                        m_tdata_reg <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

endmodule
